### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// widths, register indexes and controller/datapath command types
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int LIMIT_W   = DATA_W - 1;
   localparam int OPER_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * OPER_W;
   localparam int ACC_W     = PROD_W - FRAC_W;
   localparam int NUM_W     = OPER_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   localparam int CSR_IDX_W = 3;

   localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd4;

   typedef enum logic [1:0] {
      MUL_ERR_DT = 2'd0,
      MUL_GAIN_P = 2'd1,
      MUL_GAIN_I = 2'd2,
      MUL_GAIN_D = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        clear;
      logic        start_div;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        int_upd;
      logic        sum_add;
      logic        sum_first;
      logic        load_deriv;
      logic        clamp_out;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/pidc_datapath.sv
// ----------------------------------------------------------------------------
// pidc_datapath
// config registers, error, serial divider, shared multiplier, accumulators,
// clamps and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]           csr_data,
   input  logic                                  req_command,
   input  logic signed [pidc_pkg::DATA_W-1:0]    req_setpoint,
   input  logic signed [pidc_pkg::DATA_W-1:0]    req_measured,
   input  logic [pidc_pkg::DATA_W-1:0]           req_step_time,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [pidc_pkg::DATA_W-1:0]    rsp_drive,
   output logic                                  rsp_output_clamped,
   output logic                                  rsp_integral_clamped,
   input  pidc_pkg::dp_cmd_type                  cmd,
   output pidc_pkg::dp_status_type               status
);
   import pidc_pkg::*;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] value;
   } clamp_type;

   function automatic clamp_type clamp_mag(input logic signed [ACC_W-1:0] v,
                                           input logic [LIMIT_W-1:0] lim);
      logic signed [ACC_W-1:0] lim_pos;
      logic signed [ACC_W-1:0] lim_neg;
      clamp_type               r;
      lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, lim});
      lim_neg = -lim_pos;
      if (v > lim_pos) begin
         r.hit   = 1'b1;
         r.value = lim_pos[DATA_W-1:0];
      end else if (v < lim_neg) begin
         r.hit   = 1'b1;
         r.value = lim_neg[DATA_W-1:0];
      end else begin
         r.hit   = 1'b0;
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

   localparam logic [NUM_W-1:0] POS_MAX_Q = {{(NUM_W-DATA_W){1'b0}}, POS_MAX};
   localparam logic [NUM_W-1:0] NEG_LIM_Q = POS_MAX_Q + NUM_W'(1);

   // config
   logic signed [DATA_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIMIT_W-1:0]        out_limit_ff, int_limit_ff;

   // item and loop state
   logic                      clear_ff;
   logic [DATA_W-1:0]         dt_ff;
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic signed [DATA_W-1:0]  prev_ff;
   logic signed [DATA_W-1:0]  integral_ff;
   logic signed [DATA_W:0]    err_wide;

   // divider
   logic signed [OPER_W-1:0]  diff;
   logic [OPER_W-1:0]         diff_mag;
   logic [NUM_W-1:0]          quo_ff;
   logic [DATA_W-1:0]         rem_ff;
   logic                      neg_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;
   logic [OPER_W-1:0]         div_shift;
   logic [OPER_W:0]           div_trial;
   logic signed [DATA_W-1:0]  deriv_ff, deriv_in;

   // multiplier and sums
   logic signed [OPER_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0]   int_sum;
   logic signed [ACC_W-1:0]   sum_ff, sum_in;
   clamp_type                 int_clamp, out_clamp;

   // result
   logic signed [DATA_W-1:0]  drive_ff;
   logic                      oclamp_ff, iclamp_ff;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_drive_ff;
   logic                      rsp_oclamp_ff, rsp_iclamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         out_limit_ff <= '0;
         int_limit_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_P:         gain_p_ff    <= $signed(csr_data);
            CSR_GAIN_I:         gain_i_ff    <= $signed(csr_data);
            CSR_GAIN_D:         gain_d_ff    <= $signed(csr_data);
            CSR_OUTPUT_LIMIT:   out_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_INTEGRAL_LIMIT: int_limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturating error
   always_comb begin
      err_wide = {req_setpoint[DATA_W-1], req_setpoint}
               - {req_measured[DATA_W-1], req_measured};
      if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
         err_in = err_wide[DATA_W] ? $signed(NEG_MIN) : $signed(POS_MAX);
      end else begin
         err_in = err_wide[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         clear_ff <= req_command;
         dt_ff    <= req_step_time;
         err_ff   <= err_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      diff      = {err_ff[DATA_W-1], err_ff} - {prev_ff[DATA_W-1], prev_ff};
      diff_mag  = diff[OPER_W-1] ? -diff : diff;
      div_shift = {rem_ff, quo_ff[NUM_W-1]};
      div_trial = {1'b0, div_shift} - {2'b00, dt_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.start_div) begin
         div_cnt_ff <= (dt_ff != '0) ? DIV_CNT_W'(NUM_W) : '0;
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         quo_ff <= {diff_mag, {FRAC_W{1'b0}}};
         rem_ff <= '0;
         neg_ff <= diff[OPER_W-1];
      end else if (div_cnt_ff != '0) begin
         if (!div_trial[OPER_W]) begin
            rem_ff <= div_trial[DATA_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= div_shift[DATA_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   // signed, saturated derivative
   always_comb begin
      if (dt_ff == '0) begin
         deriv_in = '0;
      end else if (neg_ff) begin
         deriv_in = (quo_ff > NEG_LIM_Q) ? $signed(NEG_MIN) : -$signed(quo_ff[DATA_W-1:0]);
      end else begin
         deriv_in = (quo_ff > POS_MAX_Q) ? $signed(POS_MAX) : $signed(quo_ff[DATA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_deriv) begin
         deriv_ff <= deriv_in;
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_DT: begin
            mul_a = {err_ff[DATA_W-1], err_ff};
            mul_b = $signed({1'b0, dt_ff});
         end
         MUL_GAIN_P: begin
            mul_a = {gain_p_ff[DATA_W-1], gain_p_ff};
            mul_b = {err_ff[DATA_W-1], err_ff};
         end
         MUL_GAIN_I: begin
            mul_a = {gain_i_ff[DATA_W-1], gain_i_ff};
            mul_b = {integral_ff[DATA_W-1], integral_ff};
         end
         default: begin
            mul_a = {gain_d_ff[DATA_W-1], gain_d_ff};
            mul_b = {deriv_ff[DATA_W-1], deriv_ff};
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // floor shift of the product
   always_comb begin
      term      = $signed(prod_ff[PROD_W-1:FRAC_W]);
      int_sum   = $signed({{(ACC_W-DATA_W){integral_ff[DATA_W-1]}}, integral_ff}) + term;
      int_clamp = clamp_mag(int_sum, int_limit_ff);
      sum_in    = (cmd.sum_first ? '0 : sum_ff) + term;
      out_clamp = clamp_mag(sum_ff, out_limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_ff     <= '0;
      end else if (cmd.clear) begin
         integral_ff <= '0;
         prev_ff     <= '0;
      end else begin
         if (cmd.start_div) begin
            prev_ff <= err_ff;
         end
         if (cmd.int_upd) begin
            integral_ff <= int_clamp.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_add) begin
         sum_ff <= sum_in;
      end
      if (cmd.clear) begin
         iclamp_ff <= 1'b0;
      end else if (cmd.int_upd) begin
         iclamp_ff <= int_clamp.hit;
      end
      if (cmd.clear) begin
         drive_ff  <= '0;
         oclamp_ff <= 1'b0;
      end else if (cmd.clamp_out) begin
         drive_ff  <= out_clamp.value;
         oclamp_ff <= out_clamp.hit;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_drive_ff  <= drive_ff;
         rsp_oclamp_ff <= oclamp_ff;
         rsp_iclamp_ff <= iclamp_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive            = rsp_drive_ff;
   assign rsp_output_clamped   = rsp_oclamp_ff;
   assign rsp_integral_clamped = rsp_iclamp_ff;

   assign status.is_clear = clear_ff;
   assign status.div_busy = (div_cnt_ff != '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

### hw/rtl/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// pidc_ctrl
// sequencer for one control step or clear: divider start,
// multiply/accumulate schedule, clamps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pidc_pkg::dp_status_type  status,
   output pidc_pkg::dp_cmd_type     cmd
);
   import pidc_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'h0001,
      ST_FRONT    = 14'h0002,
      ST_MUL_IDT  = 14'h0004,
      ST_INT_UPD  = 14'h0008,
      ST_MUL_P    = 14'h0010,
      ST_ADD_P    = 14'h0020,
      ST_MUL_I    = 14'h0040,
      ST_ADD_I    = 14'h0080,
      ST_WAIT_DIV = 14'h0100,
      ST_MUL_D    = 14'h0200,
      ST_ADD_D    = 14'h0400,
      ST_CLAMP    = 14'h0800,
      ST_FINISH   = 14'h1000,
      ST_SPARE    = 14'h2000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_in = req_valid;
            if (req_valid) begin
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (status.is_clear) begin
               cmd.clear = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_MUL_IDT;
            end
         end
         ST_MUL_IDT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_DT;
            state_in    = ST_INT_UPD;
         end
         ST_INT_UPD: begin
            cmd.int_upd = 1'b1;
            state_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_P;
            state_in    = ST_ADD_P;
         end
         ST_ADD_P: begin
            cmd.sum_add   = 1'b1;
            cmd.sum_first = 1'b1;
            state_in      = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_I;
            state_in    = ST_ADD_I;
         end
         ST_ADD_I: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: begin
            if (!status.div_busy) begin
               cmd.load_deriv = 1'b1;
               state_in       = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN_D;
            state_in    = ST_ADD_D;
         end
         ST_ADD_D: begin
            cmd.sum_add = 1'b1;
            state_in    = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp_out = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// positional PID step in signed Q16.16 with integral and output clamps
//
//   channel   ports     direction   beat
//   request   req_*     in          command, setpoint, measured, step_time
//   response  rsp_*     out         drive, output_clamped, integral_clamped
//   config    csr_*     in          index and data, one write per cycle
//
// the 49-step serial divider for the derivative sets how long a compute
// beat takes from acceptance to the result beat; the error*dt, P and I
// multiplies run under it on one shared 33x33 multiplier
// with a zero step time the divider is skipped
// a clear beat skips the compute states; one beat is in flight at a time
// a result waits in the output register while the next beat is accepted;
// synchronous reset clears gains, limits, integral and last error
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]         csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic signed [pidc_pkg::DATA_W-1:0]  req_setpoint,
   input  logic signed [pidc_pkg::DATA_W-1:0]  req_measured,
   input  logic [pidc_pkg::DATA_W-1:0]         req_step_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pidc_pkg::DATA_W-1:0]  rsp_drive,
   output logic                                rsp_output_clamped,
   output logic                                rsp_integral_clamped
);
   import pidc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pidc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_command          (req_command),
      .req_setpoint         (req_setpoint),
      .req_measured         (req_measured),
      .req_step_time        (req_step_time),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_drive            (rsp_drive),
      .rsp_output_clamped   (rsp_output_clamped),
      .rsp_integral_clamped (rsp_integral_clamped),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

`default_nettype wire

### hw/rtl/pidc_checker.sv
// ----------------------------------------------------------------------------
// pidc_checker
// port-level checks on beat ordering and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pidc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [pidc_pkg::DATA_W-1:0]        rsp_drive,
   input logic                               rsp_output_clamped,
   input logic                               rsp_integral_clamped
);

   // a stalled result holds
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive) && $stable(rsp_output_clamped) && $stable(rsp_integral_clamped))

   // one beat in flight: busy right after acceptance
   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a result is loaded only from the busy sequence
   `ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // no result before an accepted beat has passed the front state, if none was pending
   `ASSERT_IMP(a_min_latency, clock, reset, $past(req_valid && req_ready && !rsp_valid, 2), !rsp_valid)

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);

`default_nettype wire

### verif/pid_controller_clamped_tb.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_tb
// self-checking bench for the clamped Q16.16 PID step: request beats are
// replayed from a backlog by a falling-edge driver, every accepted beat is
// run through a behavioral PID step to build the expected drive and clamp
// flags, and response beats are checked in order at the rising edge; gains
// and limits are reprogrammed between phases while the block is idle
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_tb;

   import pidc_pkg::*;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam int     IDLE_PCT      = 8;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_BEATS   = 125;
   localparam longint WORD_MAX      = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint WORD_MIN      = -WORD_MAX - 1;
   localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;

   typedef struct {
      logic                     cmd;
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] measured;
      logic [DATA_W-1:0]        step_time;
   } step_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] drive;
      logic                     out_clamped;
      logic                     int_clamped;
   } step_rsp_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [DATA_W-1:0]          csr_data;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_command;
   logic signed [DATA_W-1:0]   req_setpoint;
   logic signed [DATA_W-1:0]   req_measured;
   logic [DATA_W-1:0]          req_step_time;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [DATA_W-1:0]   rsp_drive;
   logic                       rsp_output_clamped;
   logic                       rsp_integral_clamped;

   step_req_type req_backlog[$];
   step_rsp_type drive_due[$];

   longint kp = 0, ki = 0, kd = 0;
   longint out_lim = 0, int_lim = 0;
   longint integ = 0, last_err = 0;

   logic req_taken;
   logic calm = 1'b0;
   int   cycles = 0;
   int   fails = 0;
   int   beats_checked = 0;
   int   clears_sent = 0;
   int   out_clamps = 0;
   int   int_clamps = 0;
   int   settings_used = 1;

   pid_controller_clamped dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_setpoint         (req_setpoint),
      .req_measured         (req_measured),
      .req_step_time        (req_step_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drive            (rsp_drive),
      .rsp_output_clamped   (rsp_output_clamped),
      .rsp_integral_clamped (rsp_integral_clamped)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint sat_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint clamp_to(input longint v, input longint lim, output logic hit);
      hit = 1'b1;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      hit = 1'b0;
      return v;
   endfunction

   // one positional PID step on the bench copy of gains, limits and state
   function automatic step_rsp_type pid_step(input step_req_type r);
      longint err, dt, deriv, total;
      step_rsp_type o;
      o.drive = '0;
      o.out_clamped = 1'b0;
      o.int_clamped = 1'b0;
      if (r.cmd == CMD_CLEAR) begin
         integ = 0;
         last_err = 0;
         return o;
      end
      err = sat_word(longint'(r.setpoint) - longint'(r.measured));
      dt = {32'd0, r.step_time};
      integ = clamp_to(integ + ((err * dt) >>> FRAC_W), int_lim, o.int_clamped);
      if (dt == 0)
         deriv = 0;
      else
         deriv = sat_word(((err - last_err) * (longint'(1) <<< FRAC_W)) / dt);
      total = ((kp * err) >>> FRAC_W) + ((ki * integ) >>> FRAC_W)
            + ((kd * deriv) >>> FRAC_W);
      total = clamp_to(total, out_lim, o.out_clamped);
      o.drive = total[DATA_W-1:0];
      last_err = err;
      return o;
   endfunction

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_gain();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         default: return $urandom_range(0, 32'h0100_0000);
      endcase
   endfunction

   function automatic step_req_type rand_beat();
      step_req_type r;
      r.cmd = ($urandom_range(0, 99) < 6) ? CMD_CLEAR : CMD_STEP;
      r.setpoint = rand_word();
      r.measured = rand_word();
      case ($urandom_range(0, 7))
         0:       r.step_time = '0;
         1:       r.step_time = '1;
         2:       r.step_time = $urandom;
         default: r.step_time = $urandom_range(32'h0000_0400, 32'h0004_0000);
      endcase
      return r;
   endfunction

   task automatic queue_beat(input logic cmd, input logic [DATA_W-1:0] sp,
                             input logic [DATA_W-1:0] ms, input logic [DATA_W-1:0] dt);
      step_req_type r;
      r.cmd = cmd;
      r.setpoint = sp;
      r.measured = ms;
      r.step_time = dt;
      req_backlog.push_back(r);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   task automatic program_regs(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
                               input logic [DATA_W-1:0] gd, input logic [DATA_W-1:0] ol,
                               input logic [DATA_W-1:0] il);
      csr_put(CSR_GAIN_P, gp);
      csr_put(CSR_GAIN_I, gi);
      csr_put(CSR_GAIN_D, gd);
      csr_put(CSR_OUTPUT_LIMIT, ol);
      csr_put(CSR_INTEGRAL_LIMIT, il);
      // unmapped index, must not disturb anything
      csr_put(CSR_SPARE, $urandom);
      @(negedge clock);
      csr_write <= 1'b0;
      kp = longint'($signed(gp));
      ki = longint'($signed(gi));
      kd = longint'($signed(gd));
      out_lim = {33'd0, ol[LIMIT_W-1:0]};
      int_lim = {33'd0, il[LIMIT_W-1:0]};
      settings_used++;
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || drive_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_fail(input string msg);
      fails++;
      if (fails <= 10)
         $display("%s", msg);
   endtask

   // request driver
   always @(negedge clock) begin : driver
      step_req_type nxt;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = req_backlog.pop_front();
               req_valid     <= 1'b1;
               req_command   <= nxt.cmd;
               req_setpoint  <= nxt.setpoint;
               req_measured  <= nxt.measured;
               req_step_time <= nxt.step_time;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // acceptance tracking and response check
   always @(posedge clock) begin : monitor
      step_req_type beat_in;
      step_rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected", cycles, drive_due.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         req_taken <= !reset && req_valid && req_ready;
         if (!reset && req_valid && req_ready) begin
            beat_in.cmd       = req_command;
            beat_in.setpoint  = req_setpoint;
            beat_in.measured  = req_measured;
            beat_in.step_time = req_step_time;
            if (req_command == CMD_CLEAR)
               clears_sent++;
            drive_due.push_back(pid_step(beat_in));
         end
         if (!reset && rsp_valid && rsp_ready) begin
            if (drive_due.size() == 0) begin
               note_fail($sformatf("unexpected response beat, drive %0d", rsp_drive));
            end else begin
               want = drive_due.pop_front();
               if (rsp_drive !== want.drive || rsp_output_clamped !== want.out_clamped ||
                   rsp_integral_clamped !== want.int_clamped)
                  note_fail($sformatf({"mismatch at beat %0d: drive exp %0d got %0d, ",
                                       "out clamp exp %0b got %0b, int clamp exp %0b got %0b"},
                                      beats_checked, want.drive, rsp_drive,
                                      want.out_clamped, rsp_output_clamped,
                                      want.int_clamped, rsp_integral_clamped));
               out_clamps += want.out_clamped;
               int_clamps += want.int_clamped;
            end
            beats_checked++;
         end
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_command   = CMD_STEP;
      req_setpoint  = '0;
      req_measured  = '0;
      req_step_time = '0;
      rsp_ready     = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset values: zero gains and zero limits
      queue_beat(CMD_STEP, ONE_Q, '0, ONE_Q);
      queue_beat(CMD_STEP, 32'hFFFF_0000, ONE_Q, 32'h0000_8000);
      queue_beat(CMD_CLEAR, '0, '0, '0);
      settle();

      // moderate gains, 100.0 output and 50.0 integral limits
      program_regs(ONE_Q, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000, 32'h0032_0000);
      queue_beat(CMD_STEP, ONE_Q, '0, ONE_Q);
      queue_beat(CMD_STEP, 32'h0002_0000, 32'h0000_8000, 32'h0000_8000);
      queue_beat(CMD_STEP, 32'h0003_0000, ONE_Q, '0);
      queue_beat(CMD_CLEAR, $urandom, $urandom, $urandom);
      queue_beat(CMD_STEP, 32'hFFFF_0000, ONE_Q, ONE_Q);
      queue_beat(CMD_STEP, POS_MAX, NEG_MIN, ONE_Q);
      queue_beat(CMD_STEP, NEG_MIN, POS_MAX, '1);
      queue_beat(CMD_STEP, '0, POS_MAX, 32'd1);
      queue_beat(CMD_STEP, NEG_MIN, NEG_MIN, 32'd1);
      queue_beat(CMD_STEP, POS_MAX, POS_MAX, '1);
      queue_beat(CMD_STEP, '0, '0, '0);
      queue_beat(CMD_CLEAR, '0, '0, '0);
      queue_beat(CMD_CLEAR, '1, '1, '1);
      queue_beat(CMD_STEP, '0, '1, 32'd1);
      queue_beat(CMD_STEP, POS_MAX, '0, 32'h8000_0000);
      queue_beat(CMD_STEP, NEG_MIN, '0, ONE_Q);
      queue_beat(CMD_STEP, 32'h0000_0100, '0, '0);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       program_regs(POS_MAX, NEG_MIN, POS_MAX, '1, '1);
            1:       program_regs(NEG_MIN, POS_MAX, NEG_MIN, '0, '0);
            default: program_regs(rand_gain(), rand_gain(), rand_gain(),
                                  rand_limit(), rand_limit());
         endcase
         // one phase runs without any gaps or stalls
         calm = (ph == 3);
         for (int n = 0; n < PHASE_BEATS; n++)
            req_backlog.push_back(rand_beat());
         settle();
      end
      calm = 1'b0;

      $display("checked %0d response beats over %0d register settings, %0d clears",
               beats_checked, settings_used, clears_sent);
      $display("output limit hit %0d times, integral limit hit %0d times",
               out_clamps, int_clamps);
      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures", fails);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
